// ===== hw/rtl/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and constants for the button gesture detector
// Request payloads, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned MsW    = 16;
    localparam int unsigned CountW = 16;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [1:0] {
        GST_NONE   = 2'd0,
        GST_SINGLE = 2'd1,
        GST_DOUBLE = 2'd2,
        GST_LONG   = 2'd3
    } gesture_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_DOUBLE_WIN = 2'd1,
        CFG_LONG_PRESS = 2'd2,
        CFG_ACTIVE_LOW = 2'd3
    } cfg_index_t;

    localparam logic [MsW-1:0] DebounceReset  = 16'd35;
    localparam logic [MsW-1:0] DoubleWinReset = 16'd420;
    localparam logic [MsW-1:0] LongPressReset = 16'd1300;

    localparam logic [1:0] ClickMax = 2'd3;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             pin_level;
    } in_t;

    typedef struct packed {
        gesture_t          gesture;
        logic              pressed_raw;
        logic              pressed_stable;
        logic              is_armed;
        gesture_t          last_gesture;
        logic [CountW-1:0] single_total;
        logic [CountW-1:0] double_total;
        logic [CountW-1:0] long_total;
    } out_t;

    typedef struct packed {
        logic [MsW-1:0] debounce_ms;
        logic [MsW-1:0] double_window_ms;
        logic [MsW-1:0] long_press_ms;
        logic           active_low;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgd_core.sv =====
// ----------------------------------------------------------------------------
// bgd_core: debounce, click gathering and gesture decision
// Holds the tracking state and turns one poll into one result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_core
    import bgd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic step,
    input  wire in_t  item,
    output out_t      result
);

    logic              raw_level_reg,       raw_level_next;
    logic [TimeW-1:0]  raw_change_time_reg, raw_change_time_next;
    logic              stable_level_reg,    stable_level_next;
    logic              armed_reg,           armed_next;
    logic              long_fired_reg,      long_fired_next;
    logic [1:0]        click_count_reg,     click_count_next;
    logic [TimeW-1:0]  press_time_reg,      press_time_next;
    logic [TimeW-1:0]  click_deadline_reg,  click_deadline_next;
    gesture_t          last_gesture_reg,    last_gesture_next;
    logic [CountW-1:0] single_total_reg,    single_total_next;
    logic [CountW-1:0] double_total_reg,    double_total_next;
    logic [CountW-1:0] long_total_reg,      long_total_next;

    logic             pressed;
    logic [TimeW-1:0] db_elapsed;
    logic             stable_change;
    logic [TimeW-1:0] held_time;
    logic [TimeW-1:0] window_left;
    logic             long_hit;
    logic             window_over;
    gesture_t         gesture;

    always_comb begin
        pressed = item.pin_level ^ cfg.active_low;

        // level tracking
        raw_level_next       = pressed;
        raw_change_time_next = (pressed != raw_level_reg) ? item.now_ms : raw_change_time_reg;
        db_elapsed           = item.now_ms - raw_change_time_next;
        stable_change        = (stable_level_reg != pressed) &&
                               (db_elapsed >= {{(TimeW-MsW){1'b0}}, cfg.debounce_ms});

        stable_level_next   = stable_level_reg;
        armed_next          = armed_reg;
        long_fired_next     = long_fired_reg;
        click_count_next    = click_count_reg;
        press_time_next     = press_time_reg;
        click_deadline_next = click_deadline_reg;

        if (stable_change) begin
            stable_level_next = pressed;
            if (pressed) begin
                if (armed_reg) begin
                    press_time_next = item.now_ms;
                    long_fired_next = 1'b0;
                end
            end else begin
                if (!armed_reg) begin
                    armed_next       = 1'b1;
                    click_count_next = 2'd0;
                end else if (stable_level_reg && !long_fired_reg) begin
                    if (click_count_reg != ClickMax) begin
                        click_count_next = click_count_reg + 2'd1;
                    end
                    click_deadline_next = item.now_ms +
                                          {{(TimeW-MsW){1'b0}}, cfg.double_window_ms};
                end
                long_fired_next = 1'b0;
            end
        end

        // gesture decision on the updated state, long press first
        held_time   = item.now_ms - press_time_next;
        window_left = item.now_ms - click_deadline_next;
        long_hit    = armed_next && stable_level_next && !long_fired_next &&
                      (held_time >= {{(TimeW-MsW){1'b0}}, cfg.long_press_ms});
        window_over = (click_count_next != 2'd0) && !window_left[TimeW-1];

        gesture           = GST_NONE;
        last_gesture_next = last_gesture_reg;
        single_total_next = single_total_reg;
        double_total_next = double_total_reg;
        long_total_next   = long_total_reg;

        priority if (long_hit) begin
            gesture           = GST_LONG;
            long_fired_next   = 1'b1;
            click_count_next  = 2'd0;
            long_total_next   = long_total_reg + 16'd1;
            last_gesture_next = GST_LONG;
        end else if (window_over) begin
            if (click_count_next == 2'd1) begin
                gesture           = GST_SINGLE;
                single_total_next = single_total_reg + 16'd1;
                last_gesture_next = GST_SINGLE;
            end else begin
                gesture           = GST_DOUBLE;
                double_total_next = double_total_reg + 16'd1;
                last_gesture_next = GST_DOUBLE;
            end
            click_count_next = 2'd0;
        end else begin
            gesture = GST_NONE;
        end

        result.gesture        = gesture;
        result.pressed_raw    = raw_level_next;
        result.pressed_stable = stable_level_next;
        result.is_armed       = armed_next;
        result.last_gesture   = last_gesture_next;
        result.single_total   = single_total_next;
        result.double_total   = double_total_next;
        result.long_total     = long_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_level_reg       <= 1'b0;
            raw_change_time_reg <= '0;
            stable_level_reg    <= 1'b0;
            armed_reg           <= 1'b0;
            long_fired_reg      <= 1'b0;
            click_count_reg     <= 2'd0;
            press_time_reg      <= '0;
            click_deadline_reg  <= '0;
            last_gesture_reg    <= GST_NONE;
            single_total_reg    <= '0;
            double_total_reg    <= '0;
            long_total_reg      <= '0;
        end else if (step) begin
            raw_level_reg       <= raw_level_next;
            raw_change_time_reg <= raw_change_time_next;
            stable_level_reg    <= stable_level_next;
            armed_reg           <= armed_next;
            long_fired_reg      <= long_fired_next;
            click_count_reg     <= click_count_next;
            press_time_reg      <= press_time_next;
            click_deadline_reg  <= click_deadline_next;
            last_gesture_reg    <= last_gesture_next;
            single_total_reg    <= single_total_next;
            double_total_reg    <= double_total_next;
            long_total_reg      <= long_total_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/button_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// button_gesture_detector: push button debounce, click and long press
// Polarity fix, debounce, click gathering and one gesture result per poll.
// ----------------------------------------------------------------------------
//  channel   ports                                  direction
//  s_        s_valid s_ready s_data (in_t)          poll request in
//  m_        m_valid m_ready m_data (out_t)         result request out
//  cfg_      cfg_we cfg_index cfg_wdata             register write in
//
//  one poll per cycle sustained while m_ready stays high; a poll passes
//  through the input register, then its decision into the result register
//  the decision logic runs once per cycle while step is high, that single pass sets the rate
//  reset clears all tracking state and loads the default timings
//  a stalled result holds both registers; s_ready drops only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector
    import bgd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_t                s_data,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_t                    m_data,

    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [MsW-1:0]     cfg_wdata
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    in_t  in_data_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    out_t result;
    logic step;

    // step when a poll is held and the result slot is free or being drained
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms      <= DebounceReset;
            cfg_reg.double_window_ms <= DoubleWinReset;
            cfg_reg.long_press_ms    <= LongPressReset;
            cfg_reg.active_low       <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:   cfg_reg.debounce_ms      <= cfg_wdata;
                CFG_DOUBLE_WIN: cfg_reg.double_window_ms <= cfg_wdata;
                CFG_LONG_PRESS: cfg_reg.long_press_ms    <= cfg_wdata;
                CFG_ACTIVE_LOW: cfg_reg.active_low       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    bgd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .item    (in_data_reg),
        .result  (result)
    );

endmodule

`default_nettype wire
